### rtl/scba_pkg.sv
// Shared types, constants and the bucket row-size function for the
// size-class bucket allocator. No dependencies.
package scba_pkg;

    localparam int NUM_BUCKETS   = 256;
    localparam int BUCKET_BITS   = 8;
    localparam int SIZE_BITS     = 17;
    localparam int MODE_BITS     = 2;
    localparam int ROWS_OUT_BITS = 32;
    localparam int BYTES_OUT_BITS = 48;

    localparam int COUNT_BITS_DEF = 32;
    localparam int BYTES_BITS_DEF = 48;

    // First bucket of the logarithmic groups and the smallest size that reaches it.
    localparam logic [BUCKET_BITS-1:0] FIRST_GROUP_BUCKET = 8'd64;
    localparam logic [BUCKET_BITS-1:0] LAST_BUCKET        = 8'd255;
    localparam logic [SIZE_BITS-1:0]   GROUP_BASE_BYTES   = 17'd1024;
    localparam logic [SIZE_BITS-1:0]   SMALL_STEP_BYTES   = 17'd16;

    typedef enum logic [MODE_BITS-1:0] {
        MODE_ALLOC      = 2'd0,
        MODE_RELEASE    = 2'd1,
        MODE_MARK_EMPTY = 2'd2
    } mode_t;

    // Counter update request from the execute stage.
    typedef struct packed {
        logic                 inc;
        logic                 dec;
        logic [SIZE_BITS-1:0] bytes;
    } cnt_op_t;

    // Row size in bytes held by bucket b.
    function automatic logic [SIZE_BITS-1:0] bucket_bytes(input logic [BUCKET_BITS-1:0] b);
        logic [2:0]           grp;
        logic [5:0]           k_plus;
        logic [SIZE_BITS-1:0] result;
        if (b < FIRST_GROUP_BUCKET)
        begin
            result = ({9'd0, b} + 17'd1) << 4;
        end
        else
        begin
            grp    = 3'((b - FIRST_GROUP_BUCKET) >> 5);
            k_plus = {1'b0, b[4:0]} + 6'd1;
            result = (GROUP_BASE_BYTES << grp) + ({11'd0, k_plus} << (4'd5 + {1'b0, grp}));
        end
        return result;
    endfunction

endpackage

### rtl/scba_chan_if.sv
// Valid/ready channel interfaces for the request and response sides of the
// size-class bucket allocator. Depends on scba_pkg.
interface scba_req_if;
    logic                                valid;
    logic                                ready;
    logic [scba_pkg::MODE_BITS-1:0]      mode;
    logic [scba_pkg::SIZE_BITS-1:0]      size;
    logic [scba_pkg::BUCKET_BITS-1:0]    bucket;

    modport source (output valid, mode, size, bucket, input ready);
    modport sink   (input valid, mode, size, bucket, output ready);
endinterface

interface scba_rsp_if;
    logic                                  valid;
    logic                                  ready;
    logic [scba_pkg::BUCKET_BITS-1:0]      chosen_bucket;
    logic [scba_pkg::SIZE_BITS-1:0]        bucket_bytes;
    logic                                  reuse;
    logic [scba_pkg::ROWS_OUT_BITS-1:0]    rows_in_use;
    logic [scba_pkg::BYTES_OUT_BITS-1:0]   bytes_in_use;

    modport source (output valid, chosen_bucket, bucket_bytes, reuse, rows_in_use,
                    bytes_in_use, input ready);
    modport sink   (input valid, chosen_bucket, bucket_bytes, reuse, rows_in_use,
                    bytes_in_use, output ready);
endinterface

### rtl/scba_size_class.sv
// Maps a requested row size to its size-class bucket.
// Depends on scba_pkg.
module scba_size_class (
    input  logic [scba_pkg::SIZE_BITS-1:0]   size,
    output logic [scba_pkg::BUCKET_BITS-1:0] class_bucket,
    output logic                             direct
);

    // In the logarithmic range the bucket is 32*(log2(size)-8) plus the five
    // bits just below the leading one.
    always_comb
    begin
        direct       = 1'b0;
        class_bucket = '0;
        if (size[16])
        begin
            direct       = 1'b1;
            class_bucket = scba_pkg::LAST_BUCKET;
        end
        else if (size[15])
        begin
            class_bucket = {3'd7, size[14:10]};
        end
        else if (size[14])
        begin
            class_bucket = {3'd6, size[13:9]};
        end
        else if (size[13])
        begin
            class_bucket = {3'd5, size[12:8]};
        end
        else if (size[12])
        begin
            class_bucket = {3'd4, size[11:7]};
        end
        else if (size[11])
        begin
            class_bucket = {3'd3, size[10:6]};
        end
        else if (size[10])
        begin
            class_bucket = {3'd2, size[9:5]};
        end
        else
        begin
            direct       = 1'b1;
            class_bucket = {2'd0, size[9:4]};
        end
    end

endmodule

### rtl/scba_find_first.sv
// Finds the lowest set bit of the free map at or above a start bucket, using a
// three-level tree of 8-, 8- and 4-way priority encoders. Depends on scba_pkg.
module scba_find_first (
    input  logic [scba_pkg::NUM_BUCKETS-1:0] map,
    input  logic [scba_pkg::BUCKET_BITS-1:0] start,
    output logic                             found,
    output logic [scba_pkg::BUCKET_BITS-1:0] index
);

    localparam int NUM_OCTETS = scba_pkg::NUM_BUCKETS / 8;
    localparam int NUM_BLOCKS = NUM_OCTETS / 8;

    logic [scba_pkg::NUM_BUCKETS-1:0] masked;
    logic [NUM_OCTETS-1:0]            octet_any;
    logic [2:0]                       octet_idx [NUM_OCTETS];
    logic [NUM_BLOCKS-1:0]            block_any;
    logic [2:0]                       block_idx [NUM_BLOCKS];

    always_comb
    begin
        for (int i = 0; i < scba_pkg::NUM_BUCKETS; i++)
        begin
            masked[i] = map[i] && (scba_pkg::BUCKET_BITS'(i) >= start);
        end

        for (int g = 0; g < NUM_OCTETS; g++)
        begin
            octet_any[g] = |masked[g*8 +: 8];
            octet_idx[g] = '0;
            for (int j = 7; j >= 0; j--)
            begin
                if (masked[g*8 + j])
                begin
                    octet_idx[g] = 3'(j);
                end
            end
        end

        for (int s = 0; s < NUM_BLOCKS; s++)
        begin
            block_any[s] = |octet_any[s*8 +: 8];
            block_idx[s] = '0;
            for (int j = 7; j >= 0; j--)
            begin
                if (octet_any[s*8 + j])
                begin
                    block_idx[s] = 3'(j);
                end
            end
        end

        found = |block_any;
        index = '0;
        for (int s = NUM_BLOCKS - 1; s >= 0; s--)
        begin
            if (block_any[s])
            begin
                index = {2'(s), block_idx[s], octet_idx[{2'(s), block_idx[s]}]};
            end
        end
    end

endmodule

### rtl/scba_counters.sv
// Saturating rows-in-use and bytes-in-use counters, presented at the fixed
// widths of the response channel. Depends on scba_pkg.
module scba_counters #(
    parameter int COUNT_BITS = scba_pkg::COUNT_BITS_DEF,
    parameter int BYTES_BITS = scba_pkg::BYTES_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  scba_pkg::cnt_op_t                    op,
    output logic [scba_pkg::ROWS_OUT_BITS-1:0]   rows_in_use,
    output logic [scba_pkg::BYTES_OUT_BITS-1:0]  bytes_in_use
);

    logic [COUNT_BITS-1:0] row_count_reg;
    logic [COUNT_BITS-1:0] row_count_next;
    logic [BYTES_BITS-1:0] byte_count_reg;
    logic [BYTES_BITS-1:0] byte_count_next;
    logic [BYTES_BITS:0]   byte_sum;
    logic [BYTES_BITS-1:0] op_bytes;

    always_comb
    begin
        op_bytes        = BYTES_BITS'(op.bytes);
        byte_sum        = {1'b0, byte_count_reg} + {1'b0, op_bytes};
        row_count_next  = row_count_reg;
        byte_count_next = byte_count_reg;
        if (op.inc)
        begin
            if (row_count_reg != {COUNT_BITS{1'b1}})
            begin
                row_count_next = row_count_reg + {{(COUNT_BITS-1){1'b0}}, 1'b1};
            end
            // A carry out of the sum means the counter would pass its maximum.
            byte_count_next = byte_sum[BYTES_BITS] ? {BYTES_BITS{1'b1}}
                                                   : byte_sum[BYTES_BITS-1:0];
        end
        else if (op.dec)
        begin
            if (row_count_reg != '0)
            begin
                row_count_next = row_count_reg - {{(COUNT_BITS-1){1'b0}}, 1'b1};
            end
            byte_count_next = (byte_count_reg > op_bytes) ? byte_count_reg - op_bytes : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg  <= '0;
            byte_count_reg <= '0;
        end
        else
        begin
            row_count_reg  <= row_count_next;
            byte_count_reg <= byte_count_next;
        end
    end

    generate
        if (COUNT_BITS >= scba_pkg::ROWS_OUT_BITS)
        begin : g_rows_trunc
            assign rows_in_use = row_count_reg[scba_pkg::ROWS_OUT_BITS-1:0];
        end
        else
        begin : g_rows_ext
            assign rows_in_use = {{(scba_pkg::ROWS_OUT_BITS-COUNT_BITS){1'b0}}, row_count_reg};
        end

        if (BYTES_BITS >= scba_pkg::BYTES_OUT_BITS)
        begin : g_bytes_trunc
            assign bytes_in_use = byte_count_reg[scba_pkg::BYTES_OUT_BITS-1:0];
        end
        else
        begin : g_bytes_ext
            assign bytes_in_use = {{(scba_pkg::BYTES_OUT_BITS-BYTES_BITS){1'b0}}, byte_count_reg};
        end
    endgenerate

endmodule

### rtl/size_class_bucket_allocator.sv
// Size-class bucket allocator: takes one request per clock cycle and gives one
// response per request. Each request is held in an input register, from which the
// size-class map, the combinational search of the 256-bit free map and the counter
// update run and the response is registered. The free map and counters move when
// a request passes to the response register, so back-to-back requests see each
// other's effects. A stalled response holds the input register, and the request
// side stalls only when both are full. Depends on scba_pkg, scba_chan_if,
// scba_size_class, scba_find_first and scba_counters.
module size_class_bucket_allocator #(
    parameter int COUNT_BITS = scba_pkg::COUNT_BITS_DEF,
    parameter int BYTES_BITS = scba_pkg::BYTES_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    scba_req_if.sink     req,
    scba_rsp_if.source   rsp
);

    logic                                in_valid_reg;
    logic [scba_pkg::MODE_BITS-1:0]      mode_reg;
    logic [scba_pkg::SIZE_BITS-1:0]      size_reg;
    logic [scba_pkg::BUCKET_BITS-1:0]    bucket_reg;

    logic                                out_valid_reg;
    logic [scba_pkg::BUCKET_BITS-1:0]    chosen_reg;
    logic [scba_pkg::SIZE_BITS-1:0]      bytes_reg;
    logic                                reuse_reg;

    logic [scba_pkg::NUM_BUCKETS-1:0]    free_map_reg;
    logic [scba_pkg::NUM_BUCKETS-1:0]    free_map_next;

    logic                                out_free;
    logic                                advance;
    logic [scba_pkg::BUCKET_BITS-1:0]    class_bucket;
    logic                                direct;
    logic                                search_found;
    logic [scba_pkg::BUCKET_BITS-1:0]    search_index;
    logic [scba_pkg::BUCKET_BITS-1:0]    chosen;
    logic [scba_pkg::SIZE_BITS-1:0]      chosen_bytes;
    logic                                reuse;
    scba_pkg::cnt_op_t                   cnt_op;

    assign out_free  = !out_valid_reg || rsp.ready;
    assign advance   = in_valid_reg && out_free;
    assign req.ready = !in_valid_reg || out_free;

    scba_size_class u_size_class (
        .size         (size_reg),
        .class_bucket (class_bucket),
        .direct       (direct)
    );

    scba_find_first u_find_first (
        .map   (free_map_reg),
        .start (class_bucket),
        .found (search_found),
        .index (search_index)
    );

    always_comb
    begin
        chosen        = bucket_reg;
        reuse         = 1'b0;
        free_map_next = free_map_reg;
        cnt_op.inc    = 1'b0;
        cnt_op.dec    = 1'b0;
        case (mode_reg)
            scba_pkg::MODE_ALLOC:
            begin
                // The search starts at the class bucket itself, so a free class
                // bucket wins; with nothing free above, or for a direct size, the class bucket stays.
                chosen     = (!direct && search_found) ? search_index : class_bucket;
                reuse      = free_map_reg[chosen];
                cnt_op.inc = advance;
            end
            scba_pkg::MODE_RELEASE:
            begin
                free_map_next[bucket_reg] = 1'b1;
                cnt_op.dec                = advance;
            end
            scba_pkg::MODE_MARK_EMPTY:
            begin
                free_map_next[bucket_reg] = 1'b0;
            end
            default:
            begin
                chosen = bucket_reg;
            end
        endcase
        chosen_bytes = scba_pkg::bucket_bytes(chosen);
        cnt_op.bytes = chosen_bytes;
    end

    scba_counters #(
        .COUNT_BITS (COUNT_BITS),
        .BYTES_BITS (BYTES_BITS)
    ) u_counters (
        .clk          (clk),
        .rst_n        (rst_n),
        .op           (cnt_op),
        .rows_in_use  (rsp.rows_in_use),
        .bytes_in_use (rsp.bytes_in_use)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            free_map_reg  <= '0;
        end
        else
        begin
            if (req.ready)
            begin
                in_valid_reg <= req.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                free_map_reg  <= free_map_next;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            mode_reg   <= req.mode;
            size_reg   <= req.size;
            bucket_reg <= req.bucket;
        end
        if (advance)
        begin
            chosen_reg <= chosen;
            bytes_reg  <= chosen_bytes;
            reuse_reg  <= reuse;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.chosen_bucket = chosen_reg;
    assign rsp.bucket_bytes  = bytes_reg;
    assign rsp.reuse         = reuse_reg;

endmodule

### rtl/scba_checker.sv
// Port-level checks for the size-class bucket allocator, attached to the top
// level by the bind statement at the end. Depends on scba_pkg.
module scba_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 rsp_valid,
    input logic                                 rsp_ready,
    input logic [scba_pkg::BUCKET_BITS-1:0]     chosen_bucket,
    input logic [scba_pkg::SIZE_BITS-1:0]       bucket_bytes,
    input logic                                 reuse,
    input logic [scba_pkg::ROWS_OUT_BITS-1:0]   rows_in_use,
    input logic [scba_pkg::BYTES_OUT_BITS-1:0]  bytes_in_use
);

    // A response that is not taken stays offered and unchanged.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(chosen_bucket)
            && $stable(bucket_bytes) && $stable(reuse) && $stable(rows_in_use)
            && $stable(bytes_in_use))
        else $error("response changed while stalled");

    a_bytes_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> bucket_bytes >= scba_pkg::SMALL_STEP_BYTES && bucket_bytes <= 17'd65536)
        else $error("bucket size out of range");

    // Buckets below the logarithmic groups hold multiples of sixteen bytes.
    a_small_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && chosen_bucket < scba_pkg::FIRST_GROUP_BUCKET
            |-> bucket_bytes == (({9'd0, chosen_bucket} + 17'd1) << 4))
        else $error("small bucket size mismatch");

    // The counters move only together with a new response.
    a_rows_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid |=> rsp_valid || ($stable(rows_in_use) && $stable(bytes_in_use)))
        else $error("counters changed with no response");

endmodule

bind size_class_bucket_allocator scba_checker u_scba_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .chosen_bucket (rsp.chosen_bucket),
    .bucket_bytes  (rsp.bucket_bytes),
    .reuse         (rsp.reuse),
    .rows_in_use   (rsp.rows_in_use),
    .bytes_in_use  (rsp.bytes_in_use)
);
